// ===== rtl/core/bmcpt_pkg.sv =====
// Shared types and constants of the bounded minimum-cost path tracer.
`default_nettype none
package bmcpt_pkg;

  localparam int ROW_W    = 10;
  localparam int COST_W   = 16;
  localparam int MAX_ROWS = 1024;
  localparam int WIN_W    = ROW_W + 2;

  localparam logic [COST_W-1:0] COST_ONES  = {COST_W{1'b1}};
  localparam logic [ROW_W:0]    ROW_LIMIT  = (ROW_W + 1)'(MAX_ROWS);

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col_upper;
    logic [ROW_W-1:0]  col_lower;
    logic [ROW_W-1:0]  col_delta;
    logic              first_column;
    logic              end_of_column;
    logic              final_column;
  } sample_t;

  typedef struct packed {
    logic [ROW_W-1:0] path_row;
    logic             path_done;
  } result_t;

  typedef struct packed {
    sample_t smp;
    logic    usable;
  } cls_t;

endpackage
`default_nettype wire

// ===== rtl/core/bmcpt_if.sv =====
// Request channel interfaces for samples and path points.
`default_nettype none
interface bmcpt_sample_if;
  import bmcpt_pkg::*;
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport mon (input valid, input data, input ready);
endinterface

interface bmcpt_result_if;
  import bmcpt_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport mon (input valid, input data, input ready);
endinterface
`default_nettype wire

// ===== rtl/core/bmcpt_front.sv =====
// Front end: holds the cost ceiling and classifies each incoming sample.
`default_nettype none
module bmcpt_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  bmcpt_sample_if.sink                  sample,
  input  wire logic                     cfg_we,
  input  wire logic [bmcpt_pkg::COST_W-1:0] cfg_wdata,
  output logic                          push_valid,
  input  wire logic                     push_ready,
  output bmcpt_pkg::cls_t               push_data
);
  import bmcpt_pkg::*;

  logic [COST_W-1:0] ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling <= COST_ONES;
    end else if (cfg_we) begin
      ceiling <= cfg_wdata;
    end
  end

  assign sample.ready     = push_ready;
  assign push_valid       = sample.valid;
  assign push_data.smp    = sample.data;
  assign push_data.usable = ({1'b0, sample.data.row} < ROW_LIMIT) &&
                            (sample.data.cost <= ceiling);

endmodule
`default_nettype wire

// ===== rtl/core/bmcpt_queue.sv =====
// Two-entry queue between the front end and the tracker.
`default_nettype none
module bmcpt_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire bmcpt_pkg::cls_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output bmcpt_pkg::cls_t      pop_data
);
  import bmcpt_pkg::*;

  cls_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bmcpt_back.sv =====
// Tracker: window test, best-row tracking and column decision with output register.
`default_nettype none
module bmcpt_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire bmcpt_pkg::cls_t pop_data,
  bmcpt_result_if.source       result
);
  import bmcpt_pkg::*;

  logic [ROW_W-1:0]  prev_point;
  logic [COST_W-1:0] best_cost;
  logic [ROW_W-1:0]  best_row;
  logic              found_any;
  logic              out_valid;
  result_t           out_data;

  sample_t                  s;
  logic                     out_free;
  logic                     step;
  logic signed [WIN_W-1:0]  prev_s;
  logic signed [WIN_W-1:0]  delta_s;
  logic signed [WIN_W-1:0]  upper_s;
  logic signed [WIN_W-1:0]  lower_s;
  logic signed [WIN_W-1:0]  row_s;
  logic signed [WIN_W-1:0]  lo_raw;
  logic signed [WIN_W-1:0]  hi_raw;
  logic signed [WIN_W-1:0]  wbeg;
  logic signed [WIN_W-1:0]  wend;
  logic                     take;
  logic                     found_next;
  logic [ROW_W-1:0]         best_row_next;
  logic                     miss;
  logic [ROW_W:0]           mid_sum;
  logic [ROW_W-1:0]         chosen;

  assign s        = pop_data.smp;
  assign out_free = !out_valid || result.ready;
  assign pop_ready = !s.end_of_column || out_free;
  assign step     = pop_valid && pop_ready;

  assign prev_s  = $signed({2'b00, prev_point});
  assign delta_s = $signed({2'b00, s.col_delta});
  assign upper_s = $signed({2'b00, s.col_upper});
  assign lower_s = $signed({2'b00, s.col_lower});
  assign row_s   = $signed({2'b00, s.row});
  assign lo_raw  = prev_s - delta_s;
  assign hi_raw  = prev_s + delta_s;

  always_comb begin
    if (s.first_column) begin
      wbeg = upper_s;
      wend = lower_s;
    end else begin
      wbeg = (lo_raw < upper_s) ? upper_s : lo_raw;
      wend = (hi_raw > lower_s) ? lower_s : hi_raw;
    end
  end

  assign take = (row_s >= wbeg) && (row_s <= wend) && pop_data.usable &&
                (!found_any || (s.cost <= best_cost));
  assign found_next    = found_any || take;
  assign best_row_next = take ? s.row : best_row;
  assign miss          = !s.first_column && ((wbeg > lower_s) || (wend < upper_s));
  assign mid_sum       = {1'b0, s.col_upper} + {1'b0, s.col_lower};

  always_comb begin
    if (miss) begin
      chosen = (wbeg > lower_s) ? s.col_lower : s.col_upper;
    end else if (found_next) begin
      chosen = best_row_next;
    end else begin
      chosen = mid_sum[ROW_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_point <= '0;
      best_cost  <= COST_ONES;
      best_row   <= '0;
      found_any  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        if (s.end_of_column) begin
          prev_point <= chosen;
          best_cost  <= COST_ONES;
          best_row   <= '0;
          found_any  <= 1'b0;
          out_valid  <= 1'b1;
        end else if (take) begin
          best_cost <= s.cost;
          best_row  <= s.row;
          found_any <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && s.end_of_column) begin
      out_data.path_row  <= chosen;
      out_data.path_done <= s.final_column;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule
`default_nettype wire

// ===== rtl/core/bounded_min_cost_path_trace_top.sv =====
// Top level of the bounded minimum-cost path tracer.
//
//   Channel   Dir   Payload                                   Handshake
//   sample    in    cost, row, bounds, delta, column flags    valid/ready
//   result    out   path_row, path_done                       valid/ready
//   cfg       in    cost_ceiling                              cfg_we, no stall
//
// One sample is taken per cycle while sample.ready is high; a result
// leaves through the two-entry queue and then the tracker's output register
// after its end-of-column sample. Reset is synchronous and restores the ceiling
// to all ones and the previous point to row zero. A stalled result only
// blocks the tracker on the next end-of-column sample; the queue then fills
// and sample.ready drops.
`default_nettype none
module bounded_min_cost_path_trace_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  bmcpt_sample_if.sink                      sample,
  bmcpt_result_if.source                    result,
  input  wire logic                         cfg_we,
  input  wire logic [bmcpt_pkg::COST_W-1:0] cfg_wdata
);
  import bmcpt_pkg::*;

  logic push_valid;
  logic push_ready;
  cls_t push_data;
  logic pop_valid;
  logic pop_ready;
  cls_t pop_data;

  bmcpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bmcpt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bmcpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule
`default_nettype wire

// ===== rtl/core/bmcpt_checker.sv =====
// Port-level checker for the path tracer and its bind to the top level.
`default_nettype none
module bmcpt_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  bmcpt_sample_if.sink     sample,
  bmcpt_result_if.source   result
);
  import bmcpt_pkg::*;

  logic [2:0] pending;
  logic       eoc_in;
  logic       res_out;

  assign eoc_in  = sample.valid && sample.ready && sample.data.end_of_column;
  assign res_out = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(eoc_in) - 3'(res_out);
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.data))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    res_out |-> pending != 3'd0)
    else $error("result without a pending column end");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd3)
    else $error("too many column ends in flight");

endmodule

bind bounded_min_cost_path_trace_top bmcpt_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .sample (sample),
  .result (result)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the bounded minimum-cost path tracer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmcpt_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int TOTAL_ITEMS  = 1000;
  localparam int NOISE_ITEMS  = 150;
  localparam int IDLE_PCT     = 19;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [COST_W-1:0] cfg_wdata = '0;

  bmcpt_sample_if smp_ch();
  bmcpt_result_if res_ch();

  bounded_min_cost_path_trace_top uut (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [COST_W-1:0] ceiling_q;
  logic [ROW_W-1:0]  prev_pt;
  logic [COST_W-1:0] best_cost;
  logic [ROW_W-1:0]  best_row;
  bit                found_any;
  logic [COST_W-1:0] last_cost;

  result_t path_points_due[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      quiet_cycles = 0;
  bit      steady = 1'b0;

  function automatic void reset_tracker();
    ceiling_q = COST_ONES;
    prev_pt   = '0;
    best_cost = COST_ONES;
    best_row  = '0;
    found_any = 1'b0;
    last_cost = '0;
  endfunction

  function automatic void trace_sample(sample_t s);
    int      wbeg;
    int      wend;
    int      up;
    int      lo;
    int      rw;
    result_t pt;
    up = int'(s.col_upper);
    lo = int'(s.col_lower);
    rw = int'(s.row);
    if (s.first_column) begin
      wbeg = up;
      wend = lo;
    end else begin
      wbeg = int'(prev_pt) - int'(s.col_delta);
      if (wbeg < up) wbeg = up;
      wend = int'(prev_pt) + int'(s.col_delta);
      if (wend > lo) wend = lo;
    end
    if (rw >= wbeg && rw <= wend && rw < MAX_ROWS && s.cost <= ceiling_q &&
        (!found_any || s.cost <= best_cost)) begin
      best_cost = s.cost;
      best_row  = s.row;
      found_any = 1'b1;
    end
    if (s.end_of_column) begin
      if (!s.first_column && (wbeg > lo || wend < up)) begin
        pt.path_row = (wbeg > lo) ? s.col_lower : s.col_upper;
      end else if (found_any) begin
        pt.path_row = best_row;
      end else begin
        pt.path_row = ROW_W'((up + lo) / 2);
      end
      pt.path_done = s.final_column;
      path_points_due.push_back(pt);
      prev_pt   = pt.path_row;
      found_any = 1'b0;
      best_cost = COST_ONES;
      best_row  = '0;
    end
  endfunction

  function automatic sample_t make_sample(int cost, int row, int up, int lo, int dl,
                                          bit first, bit eoc, bit fin);
    sample_t s;
    s.cost          = COST_W'(cost);
    s.row           = ROW_W'(row);
    s.col_upper     = ROW_W'(up);
    s.col_lower     = ROW_W'(lo);
    s.col_delta     = ROW_W'(dl);
    s.first_column  = first;
    s.end_of_column = eoc;
    s.final_column  = fin;
    return s;
  endfunction

  function automatic int pick_cost();
    int c;
    case ($urandom_range(0, 9))
      0: c = 0;
      1: c = 65535;
      2, 3: begin
        c = int'(ceiling_q) + int'($urandom_range(0, 4)) - 2;
        if (c < 0) c = 0;
        if (c > 65535) c = 65535;
      end
      4: c = int'(last_cost);
      default: c = int'($urandom_range(0, 65535));
    endcase
    last_cost = COST_W'(c);
    return c;
  endfunction

  task automatic send_sample(input sample_t s);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      smp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    smp_ch.valid <= 1'b1;
    smp_ch.data  <= s;
    do @(posedge clk); while (!smp_ch.ready);
    trace_sample(s);
    items_sent++;
  endtask

  task automatic drain_results();
    smp_ch.valid <= 1'b0;
    do @(posedge clk); while (path_points_due.size() != 0);
  endtask

  task automatic set_cost_ceiling(input int value);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= COST_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    ceiling_q = COST_W'(value);
  endtask

  task automatic run_path(input int n_cols);
    int up;
    int lo;
    int dl;
    int center;
    int rw;
    int n;
    for (int c = 0; c < n_cols; c++) begin
      case ($urandom_range(0, 9))
        0: begin
          up = 0;
          lo = 1023;
        end
        1: begin
          up = $urandom_range(0, 1023);
          lo = $urandom_range(0, 1023);
        end
        2, 3, 4, 5: begin
          up = $urandom_range(0, int'(prev_pt));
          lo = $urandom_range(int'(prev_pt), 1023);
        end
        default: begin
          up = $urandom_range(0, 1023);
          lo = $urandom_range(up, 1023);
        end
      endcase
      case ($urandom_range(0, 7))
        0: dl = 0;
        1: dl = 1023;
        2: dl = $urandom_range(0, 1023);
        default: dl = $urandom_range(1, 16);
      endcase
      center = (c == 0) ? (up + lo) / 2 : int'(prev_pt);
      n = $urandom_range(1, 10);
      rw = center - int'($urandom_range(0, 2 * n + 2));
      if (rw < 0) rw = 0;
      for (int k = 0; k < n; k++) begin
        send_sample(make_sample(pick_cost(), rw, up, lo, dl, c == 0, k == n - 1,
                                c == n_cols - 1));
        rw += $urandom_range(1, 3);
        if (rw > 1023) rw = 1023;
      end
    end
  endtask

  task automatic test_directed();
    // A tie on cost goes to the later row of the first column.
    send_sample(make_sample(0, 9, 10, 20, 0, 1, 0, 0));
    send_sample(make_sample(100, 10, 10, 20, 0, 1, 0, 0));
    send_sample(make_sample(50, 15, 10, 20, 0, 1, 0, 0));
    send_sample(make_sample(50, 20, 10, 20, 0, 1, 1, 0));
    // The largest cost is still accepted under the reset ceiling.
    send_sample(make_sample(0, 16, 0, 1023, 3, 0, 0, 0));
    send_sample(make_sample(65535, 18, 0, 1023, 3, 0, 0, 0));
    send_sample(make_sample(65535, 23, 0, 1023, 3, 0, 1, 0));
    // The window misses the bounds on either side.
    send_sample(make_sample(0, 22, 0, 10, 2, 0, 1, 0));
    send_sample(make_sample(0, 100, 100, 200, 5, 0, 1, 0));
    // Inverted bounds in a later column.
    send_sample(make_sample(0, 250, 300, 200, 1023, 0, 1, 0));
    // Nothing inside the window gives the midpoint of the bounds.
    send_sample(make_sample(5, 1022, 0, 1023, 0, 0, 1, 1));
    send_sample(make_sample(0, 0, 1023, 1023, 1023, 1, 0, 0));
    send_sample(make_sample(0, 1023, 1023, 1023, 1023, 1, 1, 0));
    // Inverted bounds in a first column.
    send_sample(make_sample(0, 500, 900, 100, 0, 1, 1, 1));
    send_sample(make_sample(7, 0, 0, 1023, 1023, 0, 0, 0));
    send_sample(make_sample(8, 1023, 0, 1023, 1023, 0, 1, 1));
  endtask

  task automatic test_ceiling_levels();
    int levels[7];
    levels = '{0, 65535, 1, 65534, 32768, $urandom_range(0, 65535),
               $urandom_range(0, 65535)};
    foreach (levels[i]) begin
      set_cost_ceiling(levels[i]);
      run_path($urandom_range(2, 5));
    end
  endtask

  task automatic test_random_paths();
    int paths;
    paths = 0;
    while (items_sent < TOTAL_ITEMS - NOISE_ITEMS) begin
      paths++;
      if (paths % 12 == 0) begin
        if ($urandom_range(0, 3) == 0) set_cost_ceiling($urandom_range(0, 65535));
        else set_cost_ceiling(65535 - $urandom_range(0, 4096));
      end
      steady = (items_sent >= 400 && items_sent < 600);
      run_path($urandom_range(1, 8));
      if (paths % 7 == 0) drain_results();
    end
    steady = 1'b0;
  endtask

  task automatic test_noise();
    repeat (NOISE_ITEMS) begin
      send_sample(make_sample(pick_cost(), $urandom_range(0, 1023), $urandom_range(0, 1023),
                              $urandom_range(0, 1023), $urandom_range(0, 1023),
                              $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
                              $urandom_range(0, 3) == 0));
    end
  endtask

  always @(posedge clk) begin : check_points
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (path_points_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected path point: row %0d done %0b",
                   res_ch.data.path_row, res_ch.data.path_done);
        mismatches++;
      end else begin
        want = path_points_due.pop_front();
        if (res_ch.data.path_row !== want.path_row ||
            res_ch.data.path_done !== want.path_done) begin
          if (mismatches < 10)
            $display("path point mismatch: expected row %0d done %0b, got row %0d done %0b",
                     want.path_row, want.path_done,
                     res_ch.data.path_row, res_ch.data.path_done);
          mismatches++;
        end
      end
    end
    res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL bounded_min_cost_path_trace_top");
      $finish;
    end
  end

  initial begin
    smp_ch.valid = 1'b0;
    smp_ch.data  = '0;
    res_ch.ready = 1'b0;
    reset_tracker();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_ceiling_levels();
    test_random_paths();
    test_noise();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && path_points_due.size() == 0) begin
      $display("PASS bounded_min_cost_path_trace_top");
    end else begin
      $display("FAIL bounded_min_cost_path_trace_top");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bmcpt_pkg.sv
rtl/core/bmcpt_if.sv
rtl/core/bmcpt_front.sv
rtl/core/bmcpt_queue.sv
rtl/core/bmcpt_back.sv
rtl/core/bounded_min_cost_path_trace_top.sv
rtl/core/bmcpt_checker.sv
tb/tb_top.sv
